// File: design/skx_pkg.sv
// ----------------------------------------------------------------------------
// skx_pkg
// Shared types and constants for the SHA-1 counter keystream XOR block.
// ----------------------------------------------------------------------------
package skx_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] PAD_WORD0 = 32'h80000000;
	localparam logic [31:0] PAD_LEN   = 32'd512;

	localparam logic [1:0] ADDR_FIRST  = 2'd0;
	localparam logic [1:0] ADDR_SECOND = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_msg;   // start first block: message words, IV
		logic load_pad;   // start second block: padding words, chain
		logic round;      // run one round
		logic finish;     // add chaining value into state
		logic save_ks;    // latch keystream from state
	} skx_cmd_t;

endpackage

// File: design/skx_datapath.sv
// ----------------------------------------------------------------------------
// skx_datapath
// SHA-1 round unit with a 16-word message schedule window and keystream store.
// ----------------------------------------------------------------------------
module skx_datapath (
	input  logic             clk,
	input  skx_pkg::skx_cmd_t cmd,
	input  logic [6:0]       round_idx,
	input  logic [63:0]      first_half,
	input  logic [63:0]      second_half,
	input  logic [63:0]      counter,
	input  logic [3:0]       position,
	input  logic [7:0]       data_byte,
	output logic [7:0]       plain_byte
);

	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] ch0_q, ch1_q, ch2_q, ch3_q, ch4_q;
	logic [127:0] ks_q;
	logic [31:0] f, k, t, w_new;

	always_comb begin
		if (round_idx < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = skx_pkg::K0;
		end else if (round_idx < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = skx_pkg::K1;
		end else if (round_idx < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = skx_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = skx_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_msg) begin
			w_q[0] <= first_half[63:32];
			w_q[1] <= first_half[31:0];
			w_q[2] <= first_half[63:32];
			w_q[3] <= first_half[31:0];
			w_q[4] <= second_half[63:32];
			w_q[5] <= second_half[31:0];
			w_q[6] <= second_half[63:32];
			w_q[7] <= second_half[31:0];
			for (int i = 8; i < 14; i++) w_q[i] <= '0;
			w_q[14] <= counter[63:32];
			w_q[15] <= counter[31:0];
			a_q <= skx_pkg::H0; b_q <= skx_pkg::H1; c_q <= skx_pkg::H2;
			d_q <= skx_pkg::H3; e_q <= skx_pkg::H4;
			ch0_q <= skx_pkg::H0; ch1_q <= skx_pkg::H1; ch2_q <= skx_pkg::H2;
			ch3_q <= skx_pkg::H3; ch4_q <= skx_pkg::H4;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= {w_new[30:0], w_new[31]};
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end else begin
			// The padding load and the chaining add can come in the same cycle.
			if (cmd.load_pad) begin
				w_q[0] <= skx_pkg::PAD_WORD0;
				for (int i = 1; i < 15; i++) w_q[i] <= '0;
				w_q[15] <= skx_pkg::PAD_LEN;
			end
			if (cmd.finish) begin
				a_q <= a_q + ch0_q; b_q <= b_q + ch1_q; c_q <= c_q + ch2_q;
				d_q <= d_q + ch3_q; e_q <= e_q + ch4_q;
				ch0_q <= a_q + ch0_q; ch1_q <= b_q + ch1_q; ch2_q <= c_q + ch2_q;
				ch3_q <= d_q + ch3_q; ch4_q <= e_q + ch4_q;
			end
		end
		if (cmd.save_ks) ks_q <= {a_q, b_q, c_q, d_q};
	end

	// Byte 0 of the keystream sits in the top bits.
	assign plain_byte = data_byte ^ ks_q[7'd127 - {position, 3'b000} -: 8];

endmodule

// File: design/skx_ctrl.sv
// ----------------------------------------------------------------------------
// skx_ctrl
// Sequencer: runs two SHA-1 compressions when a new keystream piece is due,
// then emits one output byte per input byte.
// ----------------------------------------------------------------------------
module skx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        data_byte,
	output logic [7:0]        data_q,
	output skx_pkg::skx_cmd_t cmd,
	output logic [6:0]        round_idx,
	output logic [63:0]       counter,
	output logic [3:0]        position
);

	typedef enum logic [2:0] {
		IDLE, BLK1, FIN1, BLK2, FIN2, SAVE, OUT
	} state_t;

	state_t      state_q;
	logic        ready_q, last_q;
	logic [6:0]  rnd_q;
	logic [63:0] ctr_q;
	logic [3:0]  pos_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = (state_q == OUT);
	assign round_idx = rnd_q;
	assign counter   = ctr_q;
	assign position  = pos_q;

	always_comb begin
		cmd = '0;
		cmd.load_msg = (state_q == IDLE) && in_valid && (pos_q == 4'd0 || !ready_q);
		cmd.round    = (state_q == BLK1) || (state_q == BLK2);
		cmd.finish   = (state_q == FIN1) || (state_q == FIN2);
		cmd.load_pad = (state_q == FIN1);
		cmd.save_ks  = (state_q == SAVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b0;
			last_q  <= 1'b0;
			rnd_q   <= '0;
			ctr_q   <= '0;
			pos_q   <= '0;
			data_q  <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						data_q <= data_byte;
						last_q <= last_byte;
						rnd_q  <= '0;
						state_q <= (pos_q == 4'd0 || !ready_q) ? BLK1 : OUT;
					end
				end
				BLK1: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= FIN1;
				end
				// The finish add and the padding load share this cycle.
				FIN1: begin
					rnd_q <= '0;
					state_q <= BLK2;
				end
				BLK2: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= FIN2;
				end
				FIN2: state_q <= SAVE;
				SAVE: begin
					ready_q <= 1'b1;
					state_q <= OUT;
				end
				OUT: begin
					if (out_ready) begin
						state_q <= IDLE;
						if (last_q) begin
							ctr_q <= '0;
							pos_q <= '0;
							ready_q <= 1'b0;
						end else begin
							pos_q <= pos_q + 4'd1;
							if (pos_q == 4'hF) ctr_q <= ctr_q + 64'd1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: design/sha1_counter_keystream_xor.sv
// A byte that starts a keystream piece runs two 80-round compressions, one
// round per cycle, through states BLK1, FIN1, BLK2, FIN2 and SAVE to OUT;
// any other byte goes straight from IDLE to OUT, shown in the next cycle.
// A piece covers 16 bytes; a new byte is taken only in IDLE, after OUT.
// Reset clears counter, position and the keystream-valid flag; the
// digest registers have no reset.
// ----------------------------------------------------------------------------
// sha1_counter_keystream_xor
// XORs each data byte with a SHA-1 counter-mode keystream byte.
// ----------------------------------------------------------------------------
module sha1_counter_keystream_xor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  plain_byte
);

	logic [63:0] first_q, second_q, counter;
	logic [7:0]  data_q;
	logic [6:0]  round_idx;
	logic [3:0]  position;
	skx_pkg::skx_cmd_t cmd;

	assign pready = 1'b1;

	// Registers sit at byte addresses 0 and 8.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (psel && penable && pwrite) begin
			if ({1'b0, paddr[3]} == skx_pkg::ADDR_FIRST && paddr[2:0] == 3'b000)
				first_q <= pwdata;
			if ({1'b0, paddr[3]} == skx_pkg::ADDR_SECOND && paddr[2:0] == 3'b000)
				second_q <= pwdata;
		end
	end

	always_comb begin
		case ({1'b0, paddr[3]})
			skx_pkg::ADDR_FIRST:  prdata = first_q;
			skx_pkg::ADDR_SECOND: prdata = second_q;
			default:              prdata = '0;
		endcase
	end

	skx_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .last_byte, .out_valid, .out_ready,
		.data_byte, .data_q, .cmd, .round_idx, .counter, .position
	);

	skx_datapath u_dp (
		.clk, .cmd, .round_idx,
		.first_half(first_q), .second_half(second_q),
		.counter, .position, .data_byte(data_q), .plain_byte
	);

endmodule
